FILE: src/ipsbl_pkg.sv
// ipsbl_pkg: shared types, codes and widths for the IPv4 source blocklist.
// Used by ipsbl_cell and ipv4_source_blocklist; depends on nothing.
package ipsbl_pkg;

  localparam int ADDR_W          = 32;
  localparam int OP_W            = 2;
  localparam int STATUS_W        = 3;
  localparam int CNT_W           = 7;
  localparam int TABLE_DEPTH_DEF = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK  = 2'd0,
    OP_ADD    = 2'd1,
    OP_DELETE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPT   = 3'd0,
    ST_DROP     = 3'd1,
    ST_ADDED    = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_ENTRY    = 3'd6,
    ST_EMPTY    = 3'd7
  } status_t;

  // Broadcast control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic              shift;
    logic              load_en;
    logic [CNT_W-1:0]  load_idx;
    logic [ADDR_W-1:0] load_data;
    logic [ADDR_W-1:0] key;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

endpackage

FILE: src/ipv4_source_blocklist.sv
// ipv4_source_blocklist: top level of the IPv4 source address blocklist.
// Instantiates a chain of ipsbl_cell slots and the sequencer that drives it.
// Depends on ipsbl_pkg and ipsbl_cell.
//
// Usage
//   Input channel (in_valid / in_stall): one item is an operation and an
//   address. Check answers accept or drop, add appends (full rejected when
//   the table is full), delete removes every copy and closes the gaps,
//   list returns every stored entry in table order with last on the final
//   one (a single empty item for an empty table).
//   Result channel (out_valid / out_stall): one output register. Each item
//   carries status, entry_address, removed_count, entry_count and last.
//   Steps: check compares in the cells, then takes a registered OR;
//   delete takes one rotation step of the chain per entry, then its
//   result; list returns one entry per cycle while the receiver does
//   not stall. The rotation through the cell chain sets the pace of
//   delete and list.
//   in_stall is high whenever an item is in progress; one item at a time.
//   A stalled receiver holds the output register and pauses list steps
//   and final results; a delete rotation runs on regardless.
//   Reset clears the entry count and the control state; the slots keep
//   whatever they held and are never read before being written.
module ipv4_source_blocklist #(
  parameter int TABLE_DEPTH = ipsbl_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ipsbl_pkg::OP_W-1:0]       in_operation,
  input  logic [ipsbl_pkg::ADDR_W-1:0]     in_address,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ipsbl_pkg::STATUS_W-1:0]   out_status,
  output logic [ipsbl_pkg::ADDR_W-1:0]     out_entry_address,
  output logic [ipsbl_pkg::CNT_W-1:0]      out_removed_count,
  output logic [ipsbl_pkg::CNT_W-1:0]      out_entry_count,
  output logic                             out_last
);

  localparam logic [ipsbl_pkg::CNT_W-1:0] DEPTH_C = (ipsbl_pkg::CNT_W)'(TABLE_DEPTH);
  localparam logic [ipsbl_pkg::CNT_W-1:0] ONE_C   = (ipsbl_pkg::CNT_W)'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_CMP,
    S_CHK_OUT,
    S_ADD,
    S_ROT,
    S_FIN
  } state_t;

  state_t                          state_r, state_nxt;
  ipsbl_pkg::op_t                  op_r, op_nxt;
  logic [ipsbl_pkg::ADDR_W-1:0]    key_r, key_nxt;
  logic [ipsbl_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [ipsbl_pkg::CNT_W-1:0]     step_r, step_nxt;
  logic [ipsbl_pkg::CNT_W-1:0]     rem_r, rem_nxt;
  ipsbl_pkg::status_t              fin_status_r, fin_status_nxt;

  logic                            out_valid_r, out_valid_nxt;
  ipsbl_pkg::status_t              out_status_r, out_status_nxt;
  logic [ipsbl_pkg::ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [ipsbl_pkg::CNT_W-1:0]     out_rem_r, out_rem_nxt;
  logic [ipsbl_pkg::CNT_W-1:0]     out_cnt_r, out_cnt_nxt;
  logic                            out_last_r, out_last_nxt;

  ipsbl_pkg::cell_ctrl_t           ctrl;
  logic [ipsbl_pkg::ADDR_W-1:0]    cell_data [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]          cell_hit;

  logic                            in_acc;
  logic                            slot_free;
  logic                            head_match;
  logic                            any_hit;
  logic [ipsbl_pkg::CNT_W-1:0]     rem_inc;

  // ---------------------------------------------------------------
  // Cell chain: slot 0 is the head, data moves towards it on a shift.
  // ---------------------------------------------------------------
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [ipsbl_pkg::ADDR_W-1:0] right;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = cell_data[g+1];
    end
    ipsbl_cell #(
      .INDEX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .right_data (right),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign head_match = (cell_data[0] == key_r);
  assign any_hit    = |cell_hit;
  assign rem_inc    = rem_r + ONE_C;

  // ---------------------------------------------------------------
  // Sequencer.
  // Delete and list rotate the live part of the chain once: every step
  // the head leaves, the rest shift down, and a kept head is written back
  // at index count - 1 - removed so far. After n steps the kept entries
  // sit in slots 0..keep-1 in their original order.
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    count_nxt      = count_r;
    step_nxt       = step_r;
    rem_nxt        = rem_r;
    fin_status_nxt = fin_status_r;

    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_rem_nxt    = out_rem_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;

    ctrl.shift     = 1'b0;
    ctrl.load_en   = 1'b0;
    ctrl.load_idx  = count_r;
    ctrl.load_data = key_r;
    ctrl.key       = key_r;
    ctrl.count     = count_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt   = ipsbl_pkg::op_t'(in_operation);
          key_nxt  = in_address;
          step_nxt = '0;
          rem_nxt  = '0;
          unique case (ipsbl_pkg::op_t'(in_operation))
            ipsbl_pkg::OP_CHECK: state_nxt = S_CHK_CMP;
            ipsbl_pkg::OP_ADD:   state_nxt = S_ADD;
            ipsbl_pkg::OP_DELETE: begin
              fin_status_nxt = ipsbl_pkg::ST_NOTFOUND;
              state_nxt      = (count_r == '0) ? S_FIN : S_ROT;
            end
            ipsbl_pkg::OP_LIST: begin
              fin_status_nxt = ipsbl_pkg::ST_EMPTY;
              state_nxt      = (count_r == '0) ? S_FIN : S_ROT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_CHK_CMP: begin
        // cells register their match flags this cycle
        state_nxt = S_CHK_OUT;
      end

      S_CHK_OUT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = any_hit ? ipsbl_pkg::ST_DROP : ipsbl_pkg::ST_ACCEPT;
          out_addr_nxt   = '0;
          out_rem_nxt    = '0;
          out_cnt_nxt    = count_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_ADD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = '0;
          out_rem_nxt   = '0;
          out_last_nxt  = 1'b1;
          if (count_r < DEPTH_C) begin
            ctrl.load_en   = 1'b1;
            count_nxt      = count_r + ONE_C;
            out_status_nxt = ipsbl_pkg::ST_ADDED;
            out_cnt_nxt    = count_r + ONE_C;
          end else begin
            out_status_nxt = ipsbl_pkg::ST_FULL;
            out_cnt_nxt    = count_r;
          end
          state_nxt = S_IDLE;
        end
      end

      S_ROT: begin
        if ((op_r == ipsbl_pkg::OP_DELETE) || slot_free) begin
          ctrl.shift     = 1'b1;
          ctrl.load_en   = (op_r == ipsbl_pkg::OP_LIST) || !head_match;
          ctrl.load_idx  = count_r - ONE_C - rem_r;
          ctrl.load_data = cell_data[0];
          step_nxt       = step_r + ONE_C;
          if ((op_r == ipsbl_pkg::OP_DELETE) && head_match) begin
            rem_nxt = rem_inc;
          end
          if (op_r == ipsbl_pkg::OP_LIST) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ipsbl_pkg::ST_ENTRY;
            out_addr_nxt   = cell_data[0];
            out_rem_nxt    = '0;
            out_cnt_nxt    = count_r;
            out_last_nxt   = (step_r == count_r - ONE_C);
          end
          if (step_r == count_r - ONE_C) begin
            if (op_r == ipsbl_pkg::OP_LIST) begin
              state_nxt = S_IDLE;
            end else begin
              fin_status_nxt = (rem_nxt != '0) ? ipsbl_pkg::ST_REMOVED
                                               : ipsbl_pkg::ST_NOTFOUND;
              state_nxt      = S_FIN;
            end
          end
        end
      end

      S_FIN: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status_r;
          out_addr_nxt   = '0;
          out_rem_nxt    = rem_r;
          out_cnt_nxt    = count_r - rem_r;
          out_last_nxt   = 1'b1;
          count_nxt      = count_r - rem_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    fin_status_r <= fin_status_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_rem_r    <= out_rem_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_address = out_addr_r;
  assign out_removed_count = out_rem_r;
  assign out_entry_count   = out_cnt_r;
  assign out_last          = out_last_r;

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above table depth");

  a_rot_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |=> $stable(count_r))
    else $error("entry count changed during a rotation");

  a_rot_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) |-> (step_r < count_r) && (rem_r <= step_r))
    else $error("rotation step or removal count out of range");

  a_list_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT) && (op_r == ipsbl_pkg::OP_LIST) |-> (rem_r == '0))
    else $error("list rotation dropped an entry");

  a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && in_valid |=> (state_r != S_IDLE))
    else $error("accepted item did not start");

endmodule

FILE: src/ipsbl_cell.sv
// ipsbl_cell: one table slot of the blocklist chain.
// Holds one address, shifts towards the head, loads at its own index,
// registers a match flag. Depends on ipsbl_pkg.
module ipsbl_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  ipsbl_pkg::cell_ctrl_t            ctrl,
  input  logic [ipsbl_pkg::ADDR_W-1:0]     right_data,
  output logic [ipsbl_pkg::ADDR_W-1:0]     data,
  output logic                             hit
);

  localparam logic [ipsbl_pkg::CNT_W-1:0] INDEX_C = (ipsbl_pkg::CNT_W)'(INDEX);

  logic [ipsbl_pkg::ADDR_W-1:0] data_r;
  logic                         hit_r;

  // payload, no reset
  always_ff @(posedge clk) begin
    if (ctrl.load_en && (ctrl.load_idx == INDEX_C)) begin
      data_r <= ctrl.load_data;
    end else if (ctrl.shift) begin
      data_r <= right_data;
    end
  end

  // match only counts for a live slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= (data_r == ctrl.key) && (INDEX_C < ctrl.count);
    end
  end

  assign data = data_r;
  assign hit  = hit_r;

endmodule

FILE: bench/tb_ipv4_source_blocklist.sv
// tb_ipv4_source_blocklist: self-checking bench for the IPv4 source blocklist.
// Drives check/add/delete/list items and compares every result item against a
// shadow table kept in the bench. Depends on ipsbl_pkg and ipv4_source_blocklist.
module tb_ipv4_source_blocklist;

  localparam int DEPTH = ipsbl_pkg::TABLE_DEPTH_DEF;
  localparam int CALM_TAIL = 30;     // items at the end sent with no idling at all

  typedef struct {
    ipsbl_pkg::op_t                  op;
    logic [ipsbl_pkg::ADDR_W-1:0]    addr;
    bit                              hold;  // wait until every result is back before sending
  } blk_item_t;

  typedef struct {
    ipsbl_pkg::status_t              status;
    logic [ipsbl_pkg::ADDR_W-1:0]    entry;
    logic [ipsbl_pkg::CNT_W-1:0]     removed;
    logic [ipsbl_pkg::CNT_W-1:0]     count;
    logic                            last;
  } blk_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [ipsbl_pkg::OP_W-1:0]     in_operation = '0;
  logic [ipsbl_pkg::ADDR_W-1:0]   in_address = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [ipsbl_pkg::STATUS_W-1:0] out_status;
  logic [ipsbl_pkg::ADDR_W-1:0]   out_entry_address;
  logic [ipsbl_pkg::CNT_W-1:0]    out_removed_count;
  logic [ipsbl_pkg::CNT_W-1:0]    out_entry_count;
  logic                           out_last;

  ipv4_source_blocklist dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_address        (in_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_entry_address (out_entry_address),
    .out_removed_count (out_removed_count),
    .out_entry_count   (out_entry_count),
    .out_last          (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block: ordered table plus fill level.
  logic [ipsbl_pkg::ADDR_W-1:0] blocked [DEPTH];
  int                           held = 0;

  blk_item_t                    op_queue[$];        // items still to be driven
  blk_result_t                  pending_results[$]; // results predicted but not yet seen
  logic [ipsbl_pkg::ADDR_W-1:0] hot_addrs[$];       // small pool so that hits and duplicates occur

  int  item_total = 0;
  int  taken_count = 0;
  bit  took = 1'b0;                     // item accepted at the last rising edge
  int  fail_count = 0;
  int  results_seen = 0;
  int  op_seen [4];
  int  full_seen = 0;
  int  peak_held = 0;
  int  gap_left = 0;
  int  stall_left = 0;

  // quiet windows give stretches with no idling; the tail of the run is always calm
  function automatic bit quiet();
    return (taken_count >= item_total - CALM_TAIL) || ((taken_count / 40) % 3 == 1);
  endfunction

  function automatic void push_result(ipsbl_pkg::status_t st,
                                      logic [ipsbl_pkg::ADDR_W-1:0] entry,
                                      int removed, int count, logic last);
    blk_result_t r;
    r.status  = st;
    r.entry   = entry;
    r.removed = (ipsbl_pkg::CNT_W)'(removed);
    r.count   = (ipsbl_pkg::CNT_W)'(count);
    r.last    = last;
    pending_results.push_back(r);
  endfunction

  // Applies one operation to the shadow table and queues the results it causes.
  function automatic void apply_blocklist_op(ipsbl_pkg::op_t op,
                                             logic [ipsbl_pkg::ADDR_W-1:0] addr);
    bit hit;
    int kept;
    hit = 1'b0;
    kept = 0;
    unique case (op)
      ipsbl_pkg::OP_CHECK: begin
        for (int i = 0; i < held; i++)
          if (blocked[i] == addr) hit = 1'b1;
        push_result(hit ? ipsbl_pkg::ST_DROP : ipsbl_pkg::ST_ACCEPT, '0, 0, held, 1'b1);
      end
      ipsbl_pkg::OP_ADD: begin
        if (held < DEPTH) begin
          blocked[held] = addr;
          held++;
          push_result(ipsbl_pkg::ST_ADDED, '0, 0, held, 1'b1);
        end else begin
          full_seen++;
          push_result(ipsbl_pkg::ST_FULL, '0, 0, held, 1'b1);
        end
      end
      ipsbl_pkg::OP_DELETE: begin
        // compact in place, order of survivors kept
        for (int i = 0; i < held; i++) begin
          if (blocked[i] != addr) begin
            blocked[kept] = blocked[i];
            kept++;
          end
        end
        push_result((held != kept) ? ipsbl_pkg::ST_REMOVED : ipsbl_pkg::ST_NOTFOUND, '0,
                    held - kept, kept, 1'b1);
        held = kept;
      end
      default: begin
        if (held == 0)
          push_result(ipsbl_pkg::ST_EMPTY, '0, 0, 0, 1'b1);
        else
          for (int i = 0; i < held; i++)
            push_result(ipsbl_pkg::ST_ENTRY, blocked[i], 0, held, (i == held - 1));
      end
    endcase
    if (held > peak_held) peak_held = held;
  endfunction

  task automatic queue_item(ipsbl_pkg::op_t op, logic [ipsbl_pkg::ADDR_W-1:0] addr,
                            bit hold = 1'b0);
    blk_item_t it;
    it.op   = op;
    it.addr = addr;
    it.hold = hold;
    op_queue.push_back(it);
  endtask

  // Addresses from the hot pool for hot_pct percent, otherwise anything in the 32-bit range.
  function automatic logic [ipsbl_pkg::ADDR_W-1:0] pick_address(int hot_pct);
    if ($urandom_range(0, 99) < hot_pct)
      return hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
    return $urandom;
  endfunction

  task automatic compare_field(string name, logic [ipsbl_pkg::ADDR_W-1:0] want,
                               logic [ipsbl_pkg::ADDR_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  // Sender: new item or idle cycle chosen at the falling edge.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else if (op_queue[0].hold && pending_results.size() != 0) begin
        in_valid <= 1'b0;           // drain point: let every result come home first
      end else if (!quiet() && $urandom_range(0, 5) == 0) begin
        gap_left = $urandom_range(1, 9) - 1;
        in_valid <= 1'b0;
      end else begin
        in_operation <= op_queue[0].op;
        in_address   <= op_queue[0].addr;
        in_valid     <= 1'b1;
        void'(op_queue.pop_front());
      end
    end
  end

  // Receiver: stall in bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (rst_n && !quiet() && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Rising edge: check a delivered result first, then predict for an accepted item.
  always @(posedge clk) begin
    blk_result_t want;
    took = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected, status %0d entry 0x%0h", $time,
                 out_status, out_entry_address);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", (ipsbl_pkg::ADDR_W)'(want.status),
                      (ipsbl_pkg::ADDR_W)'(out_status));
        compare_field("entry_address", want.entry, out_entry_address);
        compare_field("removed_count", (ipsbl_pkg::ADDR_W)'(want.removed),
                      (ipsbl_pkg::ADDR_W)'(out_removed_count));
        compare_field("entry_count", (ipsbl_pkg::ADDR_W)'(want.count),
                      (ipsbl_pkg::ADDR_W)'(out_entry_count));
        compare_field("last", (ipsbl_pkg::ADDR_W)'(want.last),
                      (ipsbl_pkg::ADDR_W)'(out_last));
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      took = 1'b1;
      taken_count++;
      op_seen[in_operation]++;
      apply_blocklist_op(ipsbl_pkg::op_t'(in_operation), in_address);
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) op_seen[i] = 0;
    hot_addrs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
    for (int i = 0; i < 8; i++) hot_addrs.push_back($urandom);

    // Directed: empty-table cases, duplicates, edge addresses, compaction order.
    queue_item(ipsbl_pkg::OP_LIST, 32'h0);                     // empty list
    queue_item(ipsbl_pkg::OP_CHECK, 32'h0);
    queue_item(ipsbl_pkg::OP_DELETE, 32'h0A00_0001);           // not found on empty table
    queue_item(ipsbl_pkg::OP_ADD, 32'h0000_0000);
    queue_item(ipsbl_pkg::OP_ADD, 32'hFFFF_FFFF);
    queue_item(ipsbl_pkg::OP_ADD, 32'hC0A8_0001);
    queue_item(ipsbl_pkg::OP_ADD, 32'hC0A8_0001);              // duplicate kept
    queue_item(ipsbl_pkg::OP_ADD, 32'h7FFF_FFFF);
    queue_item(ipsbl_pkg::OP_CHECK, 32'h0000_0000);
    queue_item(ipsbl_pkg::OP_CHECK, 32'hFFFF_FFFF);
    queue_item(ipsbl_pkg::OP_CHECK, 32'hC0A8_0002);
    queue_item(ipsbl_pkg::OP_LIST, 32'hDEAD_BEEF);             // address ignored
    queue_item(ipsbl_pkg::OP_DELETE, 32'hC0A8_0001);           // removes both copies
    queue_item(ipsbl_pkg::OP_CHECK, 32'hC0A8_0001);
    queue_item(ipsbl_pkg::OP_DELETE, 32'h1234_5678);
    queue_item(ipsbl_pkg::OP_LIST, 32'h0);
    queue_item(ipsbl_pkg::OP_DELETE, 32'h0000_0000);           // head entry
    queue_item(ipsbl_pkg::OP_DELETE, 32'h7FFF_FFFF);           // tail entry
    queue_item(ipsbl_pkg::OP_LIST, 32'h0);
    queue_item(ipsbl_pkg::OP_DELETE, 32'hFFFF_FFFF);           // back to empty
    queue_item(ipsbl_pkg::OP_LIST, 32'h0);
    queue_item(ipsbl_pkg::OP_ADD, 32'h8000_0000);
    queue_item(ipsbl_pkg::OP_CHECK, 32'h8000_0000);
    queue_item(ipsbl_pkg::OP_DELETE, 32'h8000_0000);

    // Fill to the brim and beyond so that full rejection shows up.
    for (int i = 0; i < DEPTH + 4; i++) begin
      queue_item(ipsbl_pkg::OP_ADD, pick_address(30));
      if (i % 6 == 5) queue_item(ipsbl_pkg::OP_CHECK, pick_address(80));
      if (i == DEPTH - 1) queue_item(ipsbl_pkg::OP_LIST, $urandom);
    end
    queue_item(ipsbl_pkg::OP_LIST, $urandom);

    // Mixed traffic; the first item waits for a fully drained block.
    for (int i = 0; i < 125; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 35)      queue_item(ipsbl_pkg::OP_CHECK, pick_address(70), i == 0);
      else if (r < 65) queue_item(ipsbl_pkg::OP_ADD, pick_address(60), i == 0);
      else if (r < 90) queue_item(ipsbl_pkg::OP_DELETE, pick_address(80), i == 0);
      else             queue_item(ipsbl_pkg::OP_LIST, $urandom, i == 0);
    end
    item_total = op_queue.size();

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (taken_count < item_total || pending_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);           // anything stray after the last result

    $display("Covered %0d items: %0d checks, %0d adds, %0d deletes, %0d lists.",
             taken_count, op_seen[ipsbl_pkg::OP_CHECK], op_seen[ipsbl_pkg::OP_ADD],
             op_seen[ipsbl_pkg::OP_DELETE], op_seen[ipsbl_pkg::OP_LIST]);
    $display("%0d results compared, %0d full rejections, table peaked at %0d entries.",
             results_seen, full_seen, peak_held);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("Timeout with %0d items taken and %0d results outstanding", taken_count,
             pending_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
src/ipsbl_pkg.sv
src/ipsbl_cell.sv
src/ipv4_source_blocklist.sv
bench/tb_ipv4_source_blocklist.sv
